>>> design/bcf_pkg.sv
// shared types, codes and helpers for the bezier curve flattener
`timescale 1ns / 1ps

package bcf_pkg;

    // defaults for the top level parameters
    localparam int STACK_DEPTH_DEF   = 64;
    localparam int FRACTION_BITS_DEF = 16;

    // field widths
    localparam int COORD_W  = 32;
    localparam int PIXEL_W  = 16;
    localparam int THRESH_W = 15;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 15'd5;

    // command codes
    localparam logic [CMD_W-1:0] CMD_START_CUBIC = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START_QUAD  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STEP        = 2'd2;

    // step status codes
    localparam logic [STATUS_W-1:0] STATUS_EMIT  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_SPLIT = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DUP   = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd3;

    // one control point, x in the low half
    typedef struct packed {
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } t_point;

    // one segment, point 0 in the low bits
    typedef t_point [3:0] t_seg;

    // controller to datapath commands
    typedef struct packed {
        logic load_start;
        logic start_quad;
        logic pop;
        logic set_empty;
        logic eval;
        logic push_b;
        logic push_a;
        logic emit_out;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic level_zero;
        logic is_flat;
        logic out_free;
    } t_dp_stat;

    // floor of the exact mean of two coordinates
    function automatic logic signed [COORD_W-1:0] mid_coord(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        logic signed [COORD_W:0] sum;
        sum = {a[COORD_W-1], a} + {b[COORD_W-1], b};
        return sum[COORD_W:1];
    endfunction

    // midpoint of two control points
    function automatic t_point mid_point(input t_point a, input t_point b);
        t_point r;
        r.x = mid_coord(a.x, b.x);
        r.y = mid_coord(a.y, b.y);
        return r;
    endfunction

endpackage

>>> design/bcf_ctrl.sv
// sequencing state machine for start and step commands
`timescale 1ns / 1ps

module bcf_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_req_valid,
    input  logic [bcf_pkg::CMD_W-1:0]   i_req_cmd,
    output logic                        o_req_ready,
    input  bcf_pkg::t_dp_stat           i_stat,
    output bcf_pkg::t_dp_cmd            o_cmd
);
    import bcf_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EVAL   = 3'd1;
    localparam logic [2:0] ST_PUSH_B = 3'd2;
    localparam logic [2:0] ST_PUSH_A = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       w_accept;

    assign o_req_ready = (r_state == ST_IDLE);
    assign w_accept    = i_req_valid && o_req_ready;

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (i_req_cmd)
                        CMD_START_CUBIC: begin
                            o_cmd.load_start = 1'b1;
                        end
                        CMD_START_QUAD: begin
                            o_cmd.load_start = 1'b1;
                            o_cmd.start_quad = 1'b1;
                        end
                        CMD_STEP: begin
                            if (i_stat.level_zero) begin
                                o_cmd.set_empty = 1'b1;
                                n_state         = ST_FINISH;
                            end else begin
                                o_cmd.pop = 1'b1;
                                n_state   = ST_EVAL;
                            end
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = i_stat.is_flat ? ST_FINISH : ST_PUSH_B;
            end
            ST_PUSH_B: begin
                o_cmd.push_b = 1'b1;
                n_state      = ST_PUSH_A;
            end
            ST_PUSH_A: begin
                o_cmd.push_a = 1'b1;
                n_state      = ST_FINISH;
            end
            ST_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> design/bcf_datapath.sv
// segment stack, subdivision arithmetic, point filter and output register
`timescale 1ns / 1ps

module bcf_datapath #(
    parameter int STACK_DEPTH   = bcf_pkg::STACK_DEPTH_DEF,
    parameter int FRACTION_BITS = bcf_pkg::FRACTION_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  bcf_pkg::t_dp_cmd               i_cmd,
    output bcf_pkg::t_dp_stat              o_stat,
    input  bcf_pkg::t_seg                  i_seg,
    input  logic                           i_new_polyline,
    input  logic                           i_cfg_we,
    input  logic [bcf_pkg::THRESH_W-1:0]   i_cfg_wdata,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [2*bcf_pkg::PIXEL_W-1:0]  o_out_data,
    output logic [bcf_pkg::STATUS_W-1:0]   o_out_status,
    output logic                           o_out_last
);
    import bcf_pkg::*;

    localparam int AW    = $clog2(STACK_DEPTH);
    localparam int LVL_W = $clog2(STACK_DEPTH + 1);
    localparam int LIM_W = THRESH_W + FRACTION_BITS;
    localparam int CMP_W = (LIM_W > COORD_W + 1) ? LIM_W : COORD_W + 1;
    localparam logic [LVL_W-1:0] LVL_FULL = LVL_W'(STACK_DEPTH);

    // segment stack memory
    t_seg             r_mem [STACK_DEPTH];
    t_seg             r_rd_data;
    logic             w_we;
    logic [AW-1:0]    w_waddr;
    t_seg             w_wdata;
    logic [AW-1:0]    w_raddr;

    logic [LVL_W-1:0]    r_level;
    logic                r_quad;
    logic [THRESH_W-1:0] r_thr;
    logic [PIXEL_W-1:0]  r_prev_x;
    logic [PIXEL_W-1:0]  r_prev_y;
    logic                r_prev_valid;

    // split halves and pending result
    t_seg                r_half_a;
    t_seg                r_half_b;
    logic [STATUS_W-1:0] r_res_status;
    logic [PIXEL_W-1:0]  r_res_x;
    logic [PIXEL_W-1:0]  r_res_y;

    // output register
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [PIXEL_W-1:0]  r_out_x;
    logic [PIXEL_W-1:0]  r_out_y;
    logic                r_out_last;

    t_point w_p0, w_p1, w_p2, w_p3, w_pe;
    t_point w_t, w_s1, w_s2, w_t2, w_t1, w_m;
    t_seg   w_half_a, w_half_b;
    logic [CMP_W-1:0] w_lim;
    logic [CMP_W-1:0] w_adx;
    logic [CMP_W-1:0] w_ady;
    logic             w_flat;
    logic [PIXEL_W-1:0] w_px;
    logic [PIXEL_W-1:0] w_py;
    logic             w_dup;
    logic             w_out_free;
    logic             w_push;

    // magnitude of a coordinate difference
    function automatic logic [COORD_W:0] abs_diff(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        logic signed [COORD_W:0] d;
        d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        return d[COORD_W] ? -d : d;
    endfunction

    // integer pixel, truncated toward zero and saturated
    function automatic logic [PIXEL_W-1:0] to_pixel(input logic signed [COORD_W-1:0] v);
        logic [COORD_W:0]        mag;
        logic [COORD_W:0]        qm;
        logic signed [COORD_W+1:0] q;
        mag = v[COORD_W-1] ? -{v[COORD_W-1], v} : {1'b0, v};
        qm  = mag >> FRACTION_BITS;
        q   = v[COORD_W-1] ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
        if (q > (COORD_W+2)'(32767)) begin
            return PIXEL_W'(16'sd32767);
        end else if (q < -(COORD_W+2)'(32768)) begin
            return PIXEL_W'(-17'sd32768);
        end
        return q[PIXEL_W-1:0];
    endfunction

    // flatness test on the popped segment
    always_comb begin
        w_p0  = r_rd_data[0];
        w_p1  = r_rd_data[1];
        w_p2  = r_rd_data[2];
        w_p3  = r_rd_data[3];
        w_pe  = r_quad ? w_p2 : w_p3;
        w_lim = CMP_W'({r_thr, {FRACTION_BITS{1'b0}}});
        w_adx = CMP_W'(abs_diff(w_p0.x, w_pe.x));
        w_ady = CMP_W'(abs_diff(w_p0.y, w_pe.y));
        w_flat = (w_adx < w_lim) && (w_ady < w_lim);
    end

    // de casteljau midpoints and the two halves
    always_comb begin
        w_t  = mid_point(w_p1, w_p2);
        w_s1 = mid_point(w_p0, w_p1);
        w_s2 = mid_point(w_s1, w_t);
        w_t2 = mid_point(w_p2, w_p3);
        w_t1 = mid_point(w_t2, w_t);
        w_m  = mid_point(w_s2, w_t1);
        if (r_quad) begin
            w_half_b = {t_point'('0), w_p2, w_t, w_s2};
            w_half_a = {t_point'('0), w_s2, w_s1, w_p0};
        end else begin
            w_half_b = {w_p3, w_t2, w_t1, w_m};
            w_half_a = {w_m, w_s2, w_s1, w_p0};
        end
    end

    // emitted point and duplicate check
    assign w_px  = to_pixel(w_p0.x);
    assign w_py  = to_pixel(w_p0.y);
    assign w_dup = r_prev_valid && (w_px == r_prev_x) && (w_py == r_prev_y);

    // stack memory port selection
    always_comb begin
        w_push  = (i_cmd.push_b || i_cmd.push_a) && (r_level < LVL_FULL);
        w_we    = i_cmd.load_start || w_push;
        w_waddr = i_cmd.load_start ? '0 : r_level[AW-1:0];
        w_wdata = i_seg;
        if (i_cmd.load_start && i_cmd.start_quad) begin
            w_wdata[3] = '0;
        end
        if (i_cmd.push_b) begin
            w_wdata = r_half_b;
        end else if (i_cmd.push_a) begin
            w_wdata = r_half_a;
        end
        w_raddr = AW'(r_level - LVL_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (i_cmd.pop) begin
            r_rd_data <= r_mem[w_raddr];
        end
    end

    // control state: level, curve kind, threshold, previous point
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level      <= '0;
            r_quad       <= 1'b0;
            r_thr        <= THRESH_RESET;
            r_prev_x     <= '0;
            r_prev_y     <= '0;
            r_prev_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
            if (i_cmd.load_start) begin
                r_level <= LVL_W'(1);
                r_quad  <= i_cmd.start_quad;
                if (i_new_polyline) begin
                    r_prev_valid <= 1'b0;
                end
            end else if (i_cmd.pop) begin
                r_level <= r_level - LVL_W'(1);
            end else if (w_push) begin
                r_level <= r_level + LVL_W'(1);
            end
            if (i_cmd.eval && w_flat && !w_dup) begin
                r_prev_x     <= w_px;
                r_prev_y     <= w_py;
                r_prev_valid <= 1'b1;
            end
        end
    end

    // pending result and halves
    always_ff @(posedge i_clk) begin
        if (i_cmd.set_empty) begin
            r_res_status <= STATUS_EMPTY;
            r_res_x      <= '0;
            r_res_y      <= '0;
        end else if (i_cmd.eval) begin
            r_half_a <= w_half_a;
            r_half_b <= w_half_b;
            if (w_flat) begin
                r_res_status <= w_dup ? STATUS_DUP : STATUS_EMIT;
                r_res_x      <= w_px;
                r_res_y      <= w_py;
            end else begin
                r_res_status <= STATUS_SPLIT;
                r_res_x      <= '0;
                r_res_y      <= '0;
            end
        end
    end

    // output register
    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_out) begin
            r_out_status <= r_res_status;
            r_out_x      <= r_res_x;
            r_out_y      <= r_res_y;
            r_out_last   <= (r_level == '0);
        end
    end

    assign o_stat.level_zero = (r_level == '0);
    assign o_stat.is_flat    = w_flat;
    assign o_stat.out_free   = w_out_free;

    assign o_out_valid  = r_out_valid;
    assign o_out_data   = {r_out_y, r_out_x};
    assign o_out_status = r_out_status;
    assign o_out_last   = r_out_last;

endmodule

>>> design/bezier_curve_flattener_unit.sv
// top level of the adaptive bezier curve flattener
//
// Input stream: s_axis_tuser carries the command (start cubic, start
// quadratic, step) and the new-polyline flag; s_axis_tdata carries the four
// control points in signed fixed point. A start request loads the curve onto
// the segment stack and gives no result. Every step request gives exactly one
// result on the output stream: status in m_axis_tuser, the pixel point in
// m_axis_tdata and the stack-empty flag on m_axis_tlast.
// Per request: a start is taken in idle; a step on an empty stack passes
// through finish, a step that emits a point through eval and finish and a
// step that splits through eval, push_b, push_a and finish, set by the
// registered stack read and the two half writes through its one write port.
// The result sits in an output register, so the next request can be taken
// while it waits; a step whose result is ready while the register is still
// full holds in its last state until the receiver takes the earlier result.
// Reset (synchronous, active low) empties the stack, forgets the previous
// point and sets the flatness threshold to 5; the user rewrites the threshold
// via i_cfg_we and i_cfg_wdata only while idle; the block does not enforce it.
`timescale 1ns / 1ps

module bezier_curve_flattener_unit #(
    parameter int STACK_DEPTH   = bcf_pkg::STACK_DEPTH_DEF,
    parameter int FRACTION_BITS = bcf_pkg::FRACTION_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // start_x, start_y, ctrl_a_x, ctrl_a_y, ctrl_b_x, ctrl_b_y, end_x, end_y
    input  logic [8*bcf_pkg::COORD_W-1:0] s_axis_tdata,
    // command, new_polyline
    input  logic [bcf_pkg::CMD_W:0]       s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // point_x, point_y
    output logic [2*bcf_pkg::PIXEL_W-1:0] m_axis_tdata,
    // step_status
    output logic [bcf_pkg::STATUS_W-1:0]  m_axis_tuser,
    output logic                          m_axis_tlast,
    input  logic                          i_cfg_we,
    input  logic [bcf_pkg::THRESH_W-1:0]  i_cfg_wdata
);
    import bcf_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // sequencer
    bcf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .i_req_cmd   (s_axis_tuser[CMD_W-1:0]),
        .o_req_ready (s_axis_tready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // stack, arithmetic and output register
    bcf_datapath #(
        .STACK_DEPTH   (STACK_DEPTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_seg          (t_seg'(s_axis_tdata)),
        .i_new_polyline (s_axis_tuser[CMD_W]),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_out_valid    (m_axis_tvalid),
        .i_out_ready    (m_axis_tready),
        .o_out_data     (m_axis_tdata),
        .o_out_status   (m_axis_tuser),
        .o_out_last     (m_axis_tlast)
    );

endmodule
